/* sv/msaf_pkg.sv */
package msaf_pkg;

  localparam int RING_DEPTH  = 8192;
  localparam int BURST_WORDS = 8;
  localparam int PTR_W       = $clog2(RING_DEPTH);
  localparam int FILL_W      = PTR_W + 1;
  localparam int BCNT_W      = (BURST_WORDS > 1) ? $clog2(BURST_WORDS) : 1;
  localparam int QUEUE_DEPTH = 4;
  localparam int QIDX_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = QIDX_W + 1;

  localparam logic [1:0] MODE_PUSH  = 2'd0;
  localparam logic [1:0] MODE_BURST = 2'd1;
  localparam logic [1:0] MODE_FLUSH = 2'd2;

  typedef enum logic [1:0] {
    CMD_WRITE,
    CMD_BURST,
    CMD_SILENT
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t        kind;
    logic [PTR_W-1:0] addr;
    logic [7:0]       data;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } queue_head_t;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    if (p == PTR_W'(RING_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + PTR_W'(1);
    end
    return r;
  endfunction

  function automatic logic [31:0] to_stereo(input logic [7:0] b);
    logic [15:0] s;
    s = {b, 8'h00} - 16'd1;
    return {s, s};
  endfunction

endpackage

/* sv/msaf_front.sv */
module msaf_front
  import msaf_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] mode,
  input  logic [7:0] sample_byte,
  input  logic       q_ready,
  output logic       q_push,
  output cmd_t       q_cmd
);

  logic [PTR_W-1:0]  wp, wp_next;
  logic [PTR_W-1:0]  rp, rp_next;
  logic [PTR_W-1:0]  wp_inc;
  logic [FILL_W-1:0] fill;
  logic [FILL_W-1:0] rp_sum;
  logic [PTR_W-1:0]  rp_adv;
  logic              take;

  always_comb begin
    in_stall = !q_ready;
    take     = in_valid && !in_stall;
    wp_inc   = ptr_inc(wp);
    if (wp >= rp) begin
      fill = {1'b0, wp} - {1'b0, rp};
    end else begin
      fill = FILL_W'(RING_DEPTH) - {1'b0, rp} + {1'b0, wp};
    end
    rp_sum = {1'b0, rp} + FILL_W'(BURST_WORDS);
    if (rp_sum >= FILL_W'(RING_DEPTH)) begin
      rp_adv = PTR_W'(rp_sum - FILL_W'(RING_DEPTH));
    end else begin
      rp_adv = rp_sum[PTR_W-1:0];
    end

    wp_next    = wp;
    rp_next    = rp;
    q_push     = 1'b0;
    q_cmd.kind = CMD_WRITE;
    q_cmd.addr = wp;
    q_cmd.data = sample_byte;
    if (take) begin
      case (mode)
        MODE_PUSH: begin
          if (wp_inc != rp) begin
            q_push  = 1'b1;
            wp_next = wp_inc;
          end
        end
        MODE_BURST: begin
          q_push = 1'b1;
          if (fill < FILL_W'(BURST_WORDS)) begin
            q_cmd.kind = CMD_SILENT;
          end else begin
            q_cmd.kind = CMD_BURST;
            q_cmd.addr = rp;
            rp_next    = rp_adv;
          end
        end
        MODE_FLUSH: begin
          wp_next = '0;
          rp_next = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
    end else begin
      wp <= wp_next;
      rp <= rp_next;
    end
  end

endmodule

/* sv/msaf_queue.sv */
module msaf_queue
  import msaf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  input  cmd_t        push_cmd,
  output logic        ready,
  input  logic        pop,
  output queue_head_t head
);

  cmd_t              entries [QUEUE_DEPTH];
  logic [QIDX_W-1:0] wr_idx;
  logic [QIDX_W-1:0] rd_idx;
  logic [QCNT_W-1:0] count;

  always_comb begin
    ready      = count != QCNT_W'(QUEUE_DEPTH);
    head.valid = count != '0;
    head.cmd   = entries[rd_idx];
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_idx] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_idx <= '0;
      rd_idx <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_idx <= wr_idx + QIDX_W'(1);
      end
      if (pop) begin
        rd_idx <= rd_idx + QIDX_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + QCNT_W'(1);
        2'b01:   count <= count - QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

/* sv/msaf_back.sv */
module msaf_back
  import msaf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  queue_head_t head,
  output logic        pop,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] stereo_word,
  output logic        silent,
  output logic        last
);

  logic [7:0]        ring [RING_DEPTH];
  logic              burst_active, burst_active_next;
  logic [PTR_W-1:0]  baddr, baddr_next;
  logic [BCNT_W-1:0] bcnt, bcnt_next;
  logic              rd_valid;
  logic [7:0]        rd_byte;
  logic              rd_silent;
  logic              rd_last;
  logic              rd_adv;
  logic              can_issue;
  logic              issue_mem;
  logic              issue_silent;
  logic              wr_en;
  logic              burst_end;

  always_comb begin
    rd_adv            = rd_valid && (!out_valid || !out_stall);
    can_issue         = !rd_valid || rd_adv;
    burst_end         = bcnt == BCNT_W'(BURST_WORDS - 1);
    issue_mem         = 1'b0;
    issue_silent      = 1'b0;
    wr_en             = 1'b0;
    pop               = 1'b0;
    burst_active_next = burst_active;
    baddr_next        = baddr;
    bcnt_next         = bcnt;
    if (burst_active) begin
      if (can_issue) begin
        issue_mem  = 1'b1;
        baddr_next = ptr_inc(baddr);
        bcnt_next  = bcnt + BCNT_W'(1);
        if (burst_end) begin
          burst_active_next = 1'b0;
        end
      end
    end else if (head.valid) begin
      case (head.cmd.kind)
        CMD_WRITE: begin
          wr_en = 1'b1;
          pop   = 1'b1;
        end
        CMD_SILENT: begin
          if (can_issue) begin
            issue_silent = 1'b1;
            pop          = 1'b1;
          end
        end
        CMD_BURST: begin
          pop               = 1'b1;
          burst_active_next = 1'b1;
          baddr_next        = head.cmd.addr;
          bcnt_next         = '0;
        end
        default: begin
          pop = 1'b1;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      ring[head.cmd.addr] <= head.cmd.data;
    end
    if (issue_mem) begin
      rd_byte <= ring[baddr];
    end
  end

  always_ff @(posedge clk) begin
    if (issue_mem || issue_silent) begin
      rd_silent <= issue_silent;
      rd_last   <= issue_silent || burst_end;
    end
    if (rd_adv) begin
      stereo_word <= rd_silent ? 32'd0 : to_stereo(rd_byte);
      silent      <= rd_silent;
      last        <= rd_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      burst_active <= 1'b0;
      baddr        <= '0;
      bcnt         <= '0;
      rd_valid     <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      burst_active <= burst_active_next;
      baddr        <= baddr_next;
      bcnt         <= bcnt_next;
      if (issue_mem || issue_silent) begin
        rd_valid <= 1'b1;
      end else if (rd_adv) begin
        rd_valid <= 1'b0;
      end
      if (rd_adv) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

/* sv/mono_to_stereo_audio_fifo_unit.sv */
// Mono-to-stereo sample ring between an 8-bit sample source and a burst reader.
// Input channel (in_valid / in_stall): mode 0 pushes sample_byte, mode 1 asks
// for one burst of eight words, mode 2 flushes the ring, mode 3 does nothing.
// Output channel (out_valid / out_stall): stereo_word carries the 16-bit sample
// ((b << 8) - 1) in both halves; last marks the eighth word of a burst. A
// request with fewer than eight queued samples gives one word with silent and
// last set and stereo_word zero, and leaves the ring untouched.
// Throughput: one input transaction per cycle while the command queue has room;
// a burst drains at one word per cycle while the receiver does not stall,
// limited by the single ring port. The first word of a burst passes through the
// command queue, the burst state, the ring read register and the output
// register; pushes give no output. A full ring drops pushes. Reset empties
// the ring (both pointers to zero); ring contents need no clearing. When the
// receiver stalls, the output word holds, the back end stops reading, the
// four-entry queue fills and then in_stall rises.
module mono_to_stereo_audio_fifo_unit
  import msaf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  mode,
  input  logic [7:0]  sample_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] stereo_word,
  output logic        silent,
  output logic        last
);

  logic        q_ready;
  logic        q_push;
  cmd_t        q_cmd;
  logic        q_pop;
  queue_head_t q_head;

  msaf_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .mode       (mode),
    .sample_byte(sample_byte),
    .q_ready    (q_ready),
    .q_push     (q_push),
    .q_cmd      (q_cmd)
  );

  msaf_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (q_push),
    .push_cmd(q_cmd),
    .ready   (q_ready),
    .pop     (q_pop),
    .head    (q_head)
  );

  msaf_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (q_head),
    .pop        (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .stereo_word(stereo_word),
    .silent     (silent),
    .last       (last)
  );

endmodule

/* sv/msaf_checker.sv */
module msaf_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] stereo_word,
  input logic        silent,
  input logic        last
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(stereo_word) && $stable(last))
    else $error("stalled output transaction changed");

  a_silent_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && silent |-> last)
    else $error("silent result without last");

  a_silent_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && silent |-> stereo_word == 32'd0)
    else $error("silent result with nonzero word");

  a_halves_equal: assert property (@(posedge clk) disable iff (rst)
    out_valid && !silent |-> stereo_word[31:16] == stereo_word[15:0])
    else $error("stereo halves differ");

endmodule

bind mono_to_stereo_audio_fifo_unit msaf_checker u_msaf_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .stereo_word(stereo_word),
  .silent     (silent),
  .last       (last)
);

/* tb/mono_to_stereo_audio_fifo_unit_tb.sv */
`timescale 1ns / 100ps

module mono_to_stereo_audio_fifo_unit_tb;
  import msaf_pkg::*;

  localparam logic [1:0] MODE_IGNORED = 2'd3;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int HOLD_CYCLES = 300;
  localparam int TAIL_CYCLES = 20;
  localparam int SHOWN_FAULTS = 10;

  typedef struct packed {
    logic [31:0] word;
    logic        silent;
    logic        last;
  } stereo_beat_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  mode = MODE_PUSH;
  logic [7:0]  sample_byte = 8'h00;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [31:0] stereo_word;
  logic        silent;
  logic        last;

  logic [7:0]       ring_mem [RING_DEPTH];
  logic [PTR_W-1:0] wr_ptr = '0;
  logic [PTR_W-1:0] rd_ptr = '0;
  stereo_beat_t     pending_beats [$];

  bit jitter_on = 1'b1;
  int hold_ask = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int cycle_count = 0;
  int fault_count = 0;
  int beats_checked = 0;
  int push_count = 0;
  int burst_count = 0;
  int flush_count = 0;
  int drop_count = 0;
  int silent_count = 0;
  int in_stall_cycles = 0;

  mono_to_stereo_audio_fifo_unit u_top (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .mode        (mode),
    .sample_byte (sample_byte),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .stereo_word (stereo_word),
    .silent      (silent),
    .last        (last)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic logic [PTR_W-1:0] ring_advance(input logic [PTR_W-1:0] p);
    return (p == PTR_W'(RING_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  task automatic predict_transaction(input logic [1:0] m, input logic [7:0] b);
    logic [PTR_W-1:0] nxt;
    int unsigned      fill;
    logic [15:0]      sample16;
    stereo_beat_t     beat;
    case (m)
      MODE_PUSH: begin
        push_count++;
        nxt = ring_advance(wr_ptr);
        if (nxt != rd_ptr) begin
          ring_mem[wr_ptr] = b;
          wr_ptr = nxt;
        end else begin
          drop_count++;
        end
      end
      MODE_FLUSH: begin
        flush_count++;
        wr_ptr = '0;
        rd_ptr = '0;
      end
      MODE_BURST: begin
        burst_count++;
        fill = (wr_ptr >= rd_ptr) ? wr_ptr - rd_ptr : RING_DEPTH - rd_ptr + wr_ptr;
        if (fill < BURST_WORDS) begin
          silent_count++;
          beat.word = 32'h0;
          beat.silent = 1'b1;
          beat.last = 1'b1;
          pending_beats.push_back(beat);
        end else begin
          for (int i = 0; i < BURST_WORDS; i++) begin
            sample16 = ({8'h00, ring_mem[rd_ptr]} << 8) - 16'd1;
            beat.word = {sample16, sample16};
            beat.silent = 1'b0;
            beat.last = (i == BURST_WORDS - 1);
            pending_beats.push_back(beat);
            rd_ptr = ring_advance(rd_ptr);
          end
        end
      end
      default: ;
    endcase
  endtask

  task automatic offer_transaction(input logic [1:0] m, input logic [7:0] b);
    if (jitter_on && $urandom_range(0, 99) < 9) begin
      @(negedge clk) in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    mode <= m;
    sample_byte <= b;
    @(posedge clk);
    while (in_stall) begin
      in_stall_cycles++;
      @(posedge clk);
    end
    predict_transaction(m, b);
  endtask

  task automatic wait_for_drain();
    @(negedge clk) in_valid <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed_basics();
    offer_transaction(MODE_BURST, 8'hFF);
    offer_transaction(MODE_PUSH, 8'h00);
    offer_transaction(MODE_PUSH, 8'hFF);
    offer_transaction(MODE_PUSH, 8'h80);
    offer_transaction(MODE_PUSH, 8'h01);
    offer_transaction(MODE_IGNORED, 8'hA5);
    offer_transaction(MODE_PUSH, 8'hAA);
    offer_transaction(MODE_PUSH, 8'h55);
    offer_transaction(MODE_PUSH, 8'h7F);
    offer_transaction(MODE_BURST, 8'h00);
    offer_transaction(MODE_PUSH, 8'hFE);
    offer_transaction(MODE_BURST, 8'h5A);
    offer_transaction(MODE_BURST, 8'h00);
    offer_transaction(MODE_PUSH, 8'h03);
    offer_transaction(MODE_FLUSH, 8'hC3);
    offer_transaction(MODE_BURST, 8'h00);
    offer_transaction(MODE_PUSH, 8'h09);
    offer_transaction(MODE_BURST, 8'h00);
    offer_transaction(MODE_FLUSH, 8'h00);
    wait_for_drain();
  endtask

  task automatic test_steady_stream();
    jitter_on = 1'b0;
    repeat (3 * BURST_WORDS) offer_transaction(MODE_PUSH, 8'($urandom_range(0, 255)));
    repeat (3) offer_transaction(MODE_BURST, 8'h00);
    wait_for_drain();
    jitter_on = 1'b1;
  endtask

  task automatic test_output_backpressure();
    repeat (3 * BURST_WORDS) offer_transaction(MODE_PUSH, 8'($urandom_range(0, 255)));
    hold_ask++;
    repeat (3) offer_transaction(MODE_BURST, 8'h00);
    repeat (6) offer_transaction(MODE_PUSH, 8'($urandom_range(0, 255)));
    wait_for_drain();
  endtask

  task automatic test_random_mix();
    int          counted;
    int unsigned pick;
    logic [1:0]  m;
    counted = 0;
    while (counted < 20) begin
      pick = $urandom_range(0, 99);
      if (pick < 66) m = MODE_PUSH;
      else if (pick < 88) m = MODE_BURST;
      else if (pick < 94) m = MODE_FLUSH;
      else m = MODE_IGNORED;
      offer_transaction(m, 8'($urandom_range(0, 255)));
      if (m != MODE_IGNORED) counted++;
    end
    wait_for_drain();
  endtask

  // hold the output for a long stretch on request, else stall at random
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_ask != hold_seen) begin
      hold_seen <= hold_ask;
      hold_left <= HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      out_stall <= jitter_on && ($urandom_range(0, 99) < 9);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words outstanding", cycle_count,
               pending_beats.size());
      $display("mono_to_stereo_audio_fifo_unit verification failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    stereo_beat_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_beats.size() == 0) begin
        fault_count++;
        if (fault_count <= SHOWN_FAULTS) begin
          $display("unexpected transaction: word %h silent %b last %b",
                   stereo_word, silent, last);
        end
      end else begin
        want = pending_beats.pop_front();
        beats_checked++;
        if (stereo_word !== want.word || silent !== want.silent || last !== want.last) begin
          fault_count++;
          if (fault_count <= SHOWN_FAULTS) begin
            $display("mismatch at cycle %0d: expected word %h silent %b last %b, got %h %b %b",
                     cycle_count, want.word, want.silent, want.last,
                     stereo_word, silent, last);
          end
        end
      end
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk) rst <= 1'b0;
    test_directed_basics();
    test_steady_stream();
    test_output_backpressure();
    test_random_mix();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_beats.size() != 0) begin
      $display("%0d expected words never arrived", pending_beats.size());
    end
    $display("covered %0d pushes (%0d dropped on a full ring), %0d bursts, %0d flushes",
             push_count, drop_count, burst_count, flush_count);
    $display("checked %0d output words, %0d silent; input stalled %0d cycles",
             beats_checked, silent_count, in_stall_cycles);
    if (fault_count == 0 && pending_beats.size() == 0) begin
      $display("mono_to_stereo_audio_fifo_unit verification clean");
    end else begin
      $display("mono_to_stereo_audio_fifo_unit verification failed");
    end
    $finish;
  end

endmodule
